/* sv/boundary_tag_first_fit_allocator_core_defines.svh */
// Assertion macros for the boundary tag allocator core
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

`define BTFF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btff check failed");

`define BTFF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btff check failed");

`endif

/* sv/btff_pkg.sv */
// Shared types and codes for the boundary tag allocator
`timescale 1ns / 1ps
package btff_pkg;
	typedef enum logic [3:0] {
		S_INIT0,
		S_INIT1,
		S_IDLE,
		S_WALK,
		S_WRITE,
		S_BACK_RD,
		S_BACK,
		S_FWD_RD,
		S_FWD,
		S_DONE
	} btff_state_t;

	localparam logic [1:0] STATUS_GRANTED = 2'd0;
	localparam logic [1:0] STATUS_REFUSED = 2'd1;
	localparam logic [1:0] STATUS_FREED   = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam int HeapLowBound = 32;
	localparam int HeapResetBytes = 4096;
endpackage

/* sv/btff_tag_ram.sv */
// Tag memory: one write port, one registered read port
`timescale 1ns / 1ps
module btff_tag_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 14,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

/* sv/boundary_tag_first_fit_allocator_core.sv */
// Top level: boundary tag first-fit allocator with coalescing
//  channel | direction | handshake               | word
//  req     | in        | req_valid / req_stall   | req_type, req_size, free_offset
//  rsp     | out       | rsp_valid / rsp_stall   | status, payload_offset, granted_bytes
//  apb     | in        | psel/penable/pwrite     | heap size register, paddr[2] low
// Allocate: walk the blocks from the start of the heap, then 2 or 4 tag writes on a fit.
// Free: walk to the block, 2 tag writes, then per merge a read, a check and two tag writes,
// and at most a read and a check to end each direction.
// Reset and heap size writes lay down the first free block: its head tag, then its foot tag.
// req_stall stays high from acceptance until the result is in the output register.
// A stalled result holds; the next word is accepted while it waits.
`timescale 1ns / 1ps
`include "boundary_tag_first_fit_allocator_core_defines.svh"
module boundary_tag_first_fit_allocator_core import btff_pkg::*; #(
	parameter int HEAP_BYTES = 4096,
	parameter int TAG_BYTES = 8,
	localparam int AW = $clog2(HEAP_BYTES),
	localparam int PW = AW + 1,
	localparam int XW = ((PW > 13) ? PW : 13) + 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [12:0] req_size,
	input  logic [11:0] free_offset,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [11:0] payload_offset,
	output logic [12:0] granted_bytes
);
	localparam int LoBytes = (HeapLowBound > 2 * TAG_BYTES) ? HeapLowBound : 2 * TAG_BYTES;
	localparam int RstBytes = (HeapResetBytes < HEAP_BYTES) ? HeapResetBytes : HEAP_BYTES;
	localparam int MinBlock = 1 + 2 * TAG_BYTES;
	localparam logic [XW-1:0] TagX = XW'(TAG_BYTES);
	localparam logic [XW-1:0] SplitX = XW'(2 * TAG_BYTES + MinBlock);

	btff_state_t state_q, state_d, nxt_q;
	logic [PW-1:0] heap_q, heap_d;
	logic          cfg_wr, acc;
	logic          req_type_q;
	logic [12:0]   req_size_q;
	logic [11:0]   free_off_q;
	logic [PW-1:0] h_q, f_q;
	logic [AW-1:0] wa_q [4];
	logic [PW:0]   wd_q [4];
	logic [1:0]    wi_q, wn_q;
	logic [1:0]    res_status_q;
	logic [11:0]   res_off_q;
	logic [12:0]   res_bytes_q;
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic [11:0]   payload_offset_q;
	logic [12:0]   granted_bytes_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [PW:0]   mem_wd, rd_data;

	logic          tag_free, hit_alloc, split, free_hit, walk_end, back_ok, too_big, out_free;
	logic [XW-1:0] tag_sz, h_x, f_x, req_x, last_x, free_amt_x;
	logic [XW-1:0] blk_foot, pf, back, h_back, f_fwd;
	logic [12:0]   wv;

	btff_tag_ram #(.DEPTH(HEAP_BYTES), .WIDTH(PW + 1)) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.wr_addr(mem_wa),
		.wr_data(mem_wd),
		.rd_addr(mem_ra),
		.rd_data(rd_data)
	);

	assign pready = 1'b1;
	assign prdata = 32'(heap_q);
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign acc = req_valid && !req_stall;
	assign wv = pwdata[12:0];

	always_comb begin
		if (32'(wv) < LoBytes) begin
			heap_d = PW'(LoBytes);
		end else if (32'(wv) > HEAP_BYTES) begin
			heap_d = PW'(HEAP_BYTES);
		end else begin
			heap_d = PW'(wv);
		end
	end

	assign tag_free = rd_data[PW];
	assign tag_sz = XW'(rd_data[PW-1:0]);
	assign h_x = XW'(h_q);
	assign f_x = XW'(f_q);
	assign req_x = XW'(req_size_q);
	assign last_x = XW'(heap_q) - TagX;
	assign free_amt_x = XW'(heap_q) - TagX - TagX;
	assign blk_foot = h_x + TagX + tag_sz;
	assign walk_end = blk_foot >= last_x;
	assign hit_alloc = tag_free && (tag_sz >= req_x);
	assign split = tag_sz > (req_x + SplitX);
	assign free_hit = (h_x + TagX) == XW'(free_off_q);
	assign pf = h_x - TagX;
	assign back = tag_sz + TagX;
	assign back_ok = back <= pf;
	assign h_back = pf - back;
	assign f_fwd = f_x + TagX + TagX + tag_sz;
	assign too_big = XW'(req_size) > free_amt_x;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT0: state_d = S_INIT1;
			S_INIT1: state_d = S_IDLE;
			S_IDLE: begin
				if (cfg_wr) begin
					state_d = S_INIT0;
				end else if (acc) begin
					state_d = (req_type == REQ_ALLOC && too_big) ? S_DONE : S_WALK;
				end
			end
			S_WALK: begin
				if (req_type_q == REQ_ALLOC && hit_alloc) begin
					state_d = S_WRITE;
				end else if (req_type_q == REQ_FREE && free_hit) begin
					state_d = tag_free ? S_DONE : S_WRITE;
				end else if (walk_end) begin
					state_d = S_DONE;
				end
			end
			S_WRITE: begin
				if (wi_q == wn_q) begin
					state_d = nxt_q;
				end
			end
			S_BACK_RD: state_d = (h_x >= TagX) ? S_BACK : S_FWD_RD;
			S_BACK:    state_d = (tag_free && back_ok) ? S_WRITE : S_FWD_RD;
			S_FWD_RD:  state_d = (f_x != last_x) ? S_FWD : S_DONE;
			S_FWD:     state_d = tag_free ? S_WRITE : S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != S_IDLE) || cfg_wr;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = {1'b1, free_amt_x[PW-1:0]};
		mem_ra = h_q[AW-1:0];
		unique case (state_q)
			S_INIT0: begin
				mem_we = 1'b1;
			end
			S_INIT1: begin
				mem_we = 1'b1;
				mem_wa = last_x[AW-1:0];
			end
			S_IDLE:    mem_ra = '0;
			S_WALK:    mem_ra = blk_foot[AW-1:0] + AW'(TAG_BYTES);
			S_WRITE: begin
				mem_we = 1'b1;
				mem_wa = wa_q[wi_q];
				mem_wd = wd_q[wi_q];
			end
			S_BACK_RD: mem_ra = pf[AW-1:0];
			S_FWD_RD:  mem_ra = f_q[AW-1:0] + AW'(TAG_BYTES);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT0;
			heap_q <= PW'(RstBytes);
			rsp_valid_q <= 1'b0;
			wi_q <= '0;
			wn_q <= '0;
			nxt_q <= S_DONE;
		end else begin
			state_q <= state_d;
			if (cfg_wr && state_q == S_IDLE) begin
				heap_q <= heap_d;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_WALK: begin
					wi_q <= '0;
					nxt_q <= (req_type_q == REQ_ALLOC) ? S_DONE : S_BACK_RD;
					wn_q <= (req_type_q == REQ_ALLOC && split) ? 2'd3 : 2'd1;
				end
				S_WRITE: wi_q <= wi_q + 2'd1;
				S_BACK: begin
					wi_q <= '0;
					wn_q <= 2'd1;
					nxt_q <= S_BACK_RD;
				end
				S_FWD: begin
					wi_q <= '0;
					wn_q <= 2'd1;
					nxt_q <= S_FWD_RD;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			payload_offset_q <= res_off_q;
			granted_bytes_q <= res_bytes_q;
		end
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					req_type_q <= req_type;
					req_size_q <= req_size;
					free_off_q <= free_offset;
					h_q <= '0;
					res_status_q <= (req_type == REQ_FREE) ? STATUS_FREED : STATUS_REFUSED;
					res_off_q <= '0;
					res_bytes_q <= '0;
				end
			end
			S_WALK: begin
				if (req_type_q == REQ_ALLOC && hit_alloc) begin
					res_status_q <= STATUS_GRANTED;
					res_off_q <= 12'(h_x + TagX);
					if (split) begin
						res_bytes_q <= req_size_q;
						wa_q[0] <= h_q[AW-1:0];
						wd_q[0] <= {1'b0, req_x[PW-1:0]};
						wa_q[1] <= AW'(h_x + TagX + req_x);
						wd_q[1] <= {1'b0, req_x[PW-1:0]};
						wa_q[2] <= AW'(h_x + TagX + TagX + req_x);
						wd_q[2] <= {1'b1, PW'(tag_sz - req_x - TagX - TagX)};
						wa_q[3] <= blk_foot[AW-1:0];
						wd_q[3] <= {1'b1, PW'(tag_sz - req_x - TagX - TagX)};
					end else begin
						res_bytes_q <= 13'(tag_sz);
						wa_q[0] <= h_q[AW-1:0];
						wd_q[0] <= {1'b0, tag_sz[PW-1:0]};
						wa_q[1] <= blk_foot[AW-1:0];
						wd_q[1] <= {1'b0, tag_sz[PW-1:0]};
					end
				end else if (req_type_q == REQ_FREE && free_hit) begin
					f_q <= blk_foot[PW-1:0];
					wa_q[0] <= h_q[AW-1:0];
					wd_q[0] <= {1'b1, tag_sz[PW-1:0]};
					wa_q[1] <= blk_foot[AW-1:0];
					wd_q[1] <= {1'b1, tag_sz[PW-1:0]};
				end else begin
					h_q <= PW'(blk_foot + TagX);
				end
			end
			S_BACK: begin
				if (tag_free && back_ok) begin
					h_q <= h_back[PW-1:0];
				end
				wa_q[0] <= h_back[AW-1:0];
				wd_q[0] <= {1'b1, PW'(f_x - h_back - TagX)};
				wa_q[1] <= f_q[AW-1:0];
				wd_q[1] <= {1'b1, PW'(f_x - h_back - TagX)};
			end
			S_FWD: begin
				f_q <= f_fwd[PW-1:0];
				wa_q[0] <= f_fwd[AW-1:0];
				wd_q[0] <= {1'b1, PW'(f_fwd - h_x - TagX)};
				wa_q[1] <= h_q[AW-1:0];
				wd_q[1] <= {1'b1, PW'(f_fwd - h_x - TagX)};
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign payload_offset = payload_offset_q;
	assign granted_bytes = granted_bytes_q;

	`BTFF_ASSERT_NEXT(a_big_refused, acc && req_type == REQ_ALLOC && too_big, state_q == S_DONE)
	`BTFF_ASSERT_NEXT(a_rsp_drains, rsp_valid_q && !rsp_stall && state_q != S_DONE, !rsp_valid_q)
	`BTFF_ASSERT_NOW(a_wr_index, state_q == S_WRITE, wi_q <= wn_q)
endmodule

/* tb/boundary_tag_first_fit_allocator_core_tb.sv */
// Testbench for the boundary tag first-fit allocator core: queued driver, monitor, heap predictor
`timescale 1ns / 1ps
module boundary_tag_first_fit_allocator_core_tb;
	import btff_pkg::*;

	localparam int TAG = 8;
	localparam int HEAP_MAX = 4096;
	localparam int MIN_SPLIT = 1 + 2 * TAG;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic        kind;
		logic [12:0] size;
		logic [11:0] offs;
	} alloc_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [11:0] offs;
		logic [12:0] bytes;
	} alloc_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	logic req_type = REQ_ALLOC;
	logic [12:0] req_size = '0;
	logic [11:0] free_offset = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] status;
	logic [11:0] payload_offset;
	logic [12:0] granted_bytes;

	alloc_req_t pending_words[$];
	alloc_rsp_t expected_rsp[$];
	int unsigned live_offsets[$];

	int unsigned tag_len[HEAP_MAX];
	bit tag_open[HEAP_MAX];
	int unsigned heap_bytes;
	int unsigned free_amount;

	int snd_idle_pct = 35;
	int rcv_idle_pct = 74;
	int mismatches = 0;
	int rsp_seen = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	int cycles = 0;

	boundary_tag_first_fit_allocator_core u_dut (.*);

	always #5 clk = ~clk;

	function automatic int unsigned tlen(int unsigned pos);
		return pos < HEAP_MAX ? tag_len[pos] : 0;
	endfunction

	function automatic bit topen(int unsigned pos);
		return pos < HEAP_MAX ? tag_open[pos] : 1'b0;
	endfunction

	function automatic void tset(int unsigned pos, int unsigned len, bit open);
		if (pos < HEAP_MAX) begin
			tag_len[pos] = len;
			tag_open[pos] = open;
		end
	endfunction

	function automatic void heap_init(int unsigned bytes);
		if (bytes < 32) bytes = 32;
		if (bytes > HEAP_MAX) bytes = HEAP_MAX;
		heap_bytes = bytes;
		free_amount = bytes - 2 * TAG;
		for (int i = 0; i < HEAP_MAX; i++) begin
			tag_len[i] = 0;
			tag_open[i] = 1'b0;
		end
		tset(0, free_amount, 1'b1);
		tset(heap_bytes - TAG, free_amount, 1'b1);
	endfunction

	function automatic int unsigned carve_block(int unsigned h, int unsigned want);
		int unsigned sz, f, rest, nf;
		sz = tlen(h);
		f = h + TAG + sz;
		if (sz < want + 2 * TAG || sz - want - 2 * TAG <= MIN_SPLIT) begin
			tset(h, sz, 1'b0);
			tset(f, sz, 1'b0);
			return sz;
		end
		rest = sz - want - 2 * TAG;
		nf = h + TAG + want;
		tset(h, want, 1'b0);
		tset(nf, want, 1'b0);
		tset(nf + TAG, rest, 1'b1);
		tset(f, rest, 1'b1);
		return want;
	endfunction

	function automatic void release_and_merge(int unsigned h);
		int unsigned f, pf, back, guard;
		guard = 0;
		f = h + TAG + tlen(h);
		tset(h, tlen(h), 1'b1);
		tset(f, tlen(h), 1'b1);
		while (h != 0 && h >= TAG && topen(h - TAG) && guard++ < HEAP_MAX) begin
			pf = h - TAG;
			back = tlen(pf) + TAG;
			if (back > pf) break;
			h = pf - back;
			tset(h, f - h - TAG, 1'b1);
			tset(f, f - h - TAG, 1'b1);
		end
		while (f != heap_bytes - TAG && topen(f + TAG) && guard++ < 2 * HEAP_MAX) begin
			f = (f + TAG) + TAG + tlen(f + TAG);
			tset(f, f - h - TAG, 1'b1);
			tset(h, f - h - TAG, 1'b1);
		end
	endfunction

	function automatic alloc_rsp_t heap_serve(alloc_req_t rq);
		alloc_rsp_t r;
		int unsigned h, f, guard, got;
		r.status = STATUS_REFUSED;
		r.offs = '0;
		r.bytes = '0;
		h = 0;
		guard = 0;
		if (rq.kind == REQ_ALLOC) begin
			if (rq.size > free_amount) return r;
			while (guard++ < HEAP_MAX) begin
				if (topen(h) && tlen(h) >= rq.size) begin
					got = carve_block(h, rq.size);
					r.status = STATUS_GRANTED;
					r.offs = 12'(h + TAG);
					r.bytes = 13'(got);
					return r;
				end
				f = h + TAG + tlen(h);
				if (f >= heap_bytes - TAG) break;
				h = f + TAG;
			end
			return r;
		end
		r.status = STATUS_FREED;
		while (guard++ < HEAP_MAX) begin
			if (h + TAG == rq.offs) begin
				if (!topen(h)) release_and_merge(h);
				break;
			end
			f = h + TAG + tlen(h);
			if (f >= heap_bytes - TAG) break;
			h = f + TAG;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		alloc_req_t cur, nxt;
		alloc_rsp_t e;
		bit taken;
		cycles <= cycles + 1;
		taken = req_valid && !req_stall;
		if (taken) begin
			cur.kind = req_type;
			cur.size = req_size;
			cur.offs = free_offset;
			e = heap_serve(cur);
			expected_rsp.push_back(e);
			if (e.status == STATUS_GRANTED) live_offsets.push_back(e.offs);
		end
		if (arst_n && (!req_valid || taken)) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
				nxt = pending_words.pop_front();
				req_type <= nxt.kind;
				req_size <= nxt.size;
				free_offset <= nxt.offs;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp_stall <= 1'b1;
		end else if (rsp_seen == 1300 && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt <= 600;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		alloc_rsp_t e;
		if (rsp_valid && !rsp_stall) begin
			rsp_seen <= rsp_seen + 1;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word status=%0d", status);
			end else begin
				e = expected_rsp.pop_front();
				if (status !== e.status || payload_offset !== e.offs
						|| granted_bytes !== e.bytes) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp st=%0d off=%0d sz=%0d got st=%0d off=%0d sz=%0d",
							e.status, e.offs, e.bytes, status, payload_offset, granted_bytes);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_word(logic kind, logic [12:0] size, logic [11:0] offs);
		alloc_req_t w;
		w.kind = kind;
		w.size = size;
		w.offs = offs;
		pending_words.push_back(w);
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_heap_size(logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		heap_init(v & 32'h1FFF);
		live_offsets.delete();
		repeat (4) @(posedge clk);
	endtask

	task automatic random_words(int n);
		int r, k;
		for (int i = 0; i < n; i++) begin
			while (pending_words.size() >= 2) @(posedge clk);
			r = $urandom_range(99);
			if (live_offsets.size() > 0 && r < 42) begin
				k = $urandom_range(live_offsets.size() - 1);
				add_word(REQ_FREE, 13'($urandom), 12'(live_offsets[k]));
				live_offsets.delete(k);
			end else if (r < 50) begin
				add_word(REQ_FREE, 13'($urandom), 12'($urandom));
			end else begin
				r = $urandom_range(99);
				if (r < 80) add_word(REQ_ALLOC, 13'($urandom_range(64)), 12'($urandom));
				else if (r < 92) add_word(REQ_ALLOC, 13'($urandom_range(600, 65)), 12'($urandom));
				else if (r < 97)
					add_word(REQ_ALLOC, 13'($urandom_range(free_amount + 20)), 12'($urandom));
				else add_word(REQ_ALLOC, 13'($urandom), 12'($urandom));
			end
		end
	endtask

	initial begin
		heap_init(HeapResetBytes);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		add_word(REQ_ALLOC, 13'd0, 12'd0);
		add_word(REQ_ALLOC, 13'd100, 12'hFFF);
		add_word(REQ_ALLOC, 13'd16, 12'd0);
		add_word(REQ_FREE, 13'h1FFF, 12'd24);
		add_word(REQ_FREE, 13'd0, 12'd24);
		add_word(REQ_FREE, 13'd0, 12'd8);
		add_word(REQ_ALLOC, 13'd4081, 12'd0);
		add_word(REQ_ALLOC, 13'd4080, 12'd0);
		add_word(REQ_FREE, 13'd0, 12'd140);
		add_word(REQ_ALLOC, 13'd4080, 12'd0);
		add_word(REQ_FREE, 13'd0, 12'd8);
		add_word(REQ_ALLOC, 13'd4063, 12'd0);
		add_word(REQ_FREE, 13'd0, 12'd8);
		add_word(REQ_ALLOC, 13'h1FFF, 12'd0);
		add_word(REQ_ALLOC, 13'd4096, 12'd0);
		add_word(REQ_FREE, 13'd0, 12'hFFF);
		add_word(REQ_FREE, 13'd0, 12'd0);
		drain();

		write_heap_size(32'h1FFF);
		random_words(500);
		drain();

		snd_idle_pct = 74;
		rcv_idle_pct = 35;
		write_heap_size(32'd0);
		add_word(REQ_ALLOC, 13'd16, 12'd0);
		add_word(REQ_ALLOC, 13'd17, 12'd0);
		random_words(150);
		drain();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_heap_size(32'd4096);
		random_words(700);
		drain();

		write_heap_size($urandom_range(4096, 32));
		random_words(450);
		drain();

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
